>>> rtl/ogu_pkg.sv
// Package: shared constants, types and helpers of the occupancy grid update block
package ogu_pkg;

   localparam int CELLS_PER_BLOCK      = 16;
   localparam int MAX_BLOCKS_DEF       = 64;
   localparam int BLOCK_COORD_BITS_DEF = 12;

   localparam logic [31:0] GRID_SCALE_RESET     = 32'd1048576;
   localparam logic [14:0] LOG_ODDS_LIMIT_RESET = 15'd32767;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_SCALE     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOG_ODDS_LIMIT = 1'b1;

   localparam logic [1:0] STATUS_UPDATED  = 2'd0;
   localparam logic [1:0] STATUS_NEW      = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture request, start scaling multiply
      logic split;       // form block / cell coordinates, range check
      logic key;         // squaring for the key
      logic search;      // compare one table slot
      logic alloc;       // allocate new slot
      logic rd;          // issue cell read
      logic wr;          // saturate and write back
      logic respond;     // drive result strobe
      logic clear;       // clear one cell during reset sweep
   } ctrl_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_range;
      logic hit;
      logic last_slot;
      logic full;
      logic empty;
      logic clear_done;
   } stat_type;

endpackage

>>> rtl/occupancy_grid_log_odds_update.sv
// Top level of the occupancy grid log-odds update block
//
//  channel  handshake                 payload
//  req      start / busy              req_x_pos, req_y_pos, req_increment
//  rsp      rsp_strobe (one cycle)    rsp_status ... rsp_max_col
//  csr      csr_valid / csr_ready     csr_index, csr_data
//
// From the accepting edge a request passes the multiply, split and key states; out
// of range it then goes to the result strobe, otherwise the linear block table
// search compares slots in order, then the cell read, wait and write states run,
// which a full-table drop skips. The next request can be accepted in the strobe
// cycle. After reset a clearing sweep zeroes the cell memory, one entry a cycle,
// over MAX_BLOCKS*CELLS_PER_BLOCK^2 entries (16384 by default); busy stays high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module occupancy_grid_log_odds_update import ogu_pkg::*; #(
   parameter int MAX_BLOCKS       = MAX_BLOCKS_DEF,
   parameter int BLOCK_COORD_BITS = BLOCK_COORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_x_pos,
   input  logic signed [31:0]  req_y_pos,
   input  logic signed [15:0]  req_increment,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic signed [11:0]  rsp_block_row,
   output logic signed [11:0]  rsp_block_col,
   output logic [3:0]          rsp_cell_row,
   output logic [3:0]          rsp_cell_col,
   output logic [24:0]         rsp_block_key,
   output logic signed [15:0]  rsp_log_odds,
   output logic signed [11:0]  rsp_min_row,
   output logic signed [11:0]  rsp_max_row,
   output logic signed [11:0]  rsp_min_col,
   output logic signed [11:0]  rsp_max_col,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]         csr_data
);
   ctrl_type ctrl;
   stat_type stat;

   assign csr_ready = 1'b1;

   ogu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ogu_datapath #(
      .MAX_BLOCKS       (MAX_BLOCKS),
      .BLOCK_COORD_BITS (BLOCK_COORD_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .x_pos         (req_x_pos),
      .y_pos         (req_y_pos),
      .increment     (req_increment),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_block_row (rsp_block_row),
      .rsp_block_col (rsp_block_col),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_block_key (rsp_block_key),
      .rsp_log_odds  (rsp_log_odds),
      .rsp_min_row   (rsp_min_row),
      .rsp_max_row   (rsp_max_row),
      .rsp_min_col   (rsp_min_col),
      .rsp_max_col   (rsp_max_col)
   );
endmodule

>>> rtl/ogu_ram.sv
// Generic single-port RAM with registered read
module ogu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> rtl/ogu_ctrl.sv
// Controller state machine of the occupancy grid update block
module ogu_ctrl import ogu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output ctrl_type ctrl
);
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_SPLIT  = 4'd3;
   localparam logic [3:0] S_KEY    = 4'd4;
   localparam logic [3:0] S_SEARCH = 4'd5;
   localparam logic [3:0] S_RD     = 4'd6;
   localparam logic [3:0] S_WAIT   = 4'd7;
   localparam logic [3:0] S_WR     = 4'd8;
   localparam logic [3:0] S_RSP    = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            ctrl.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_MUL;
            end
         end
         // product registers at the end of this cycle
         S_MUL: begin
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            ctrl.split = 1'b1;
            state_in   = S_KEY;
         end
         S_KEY: begin
            if (stat.out_range) begin
               state_in = S_RSP;
            end else begin
               ctrl.key = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (stat.empty) begin
               if (stat.full) begin
                  state_in = S_RSP;
               end else begin
                  ctrl.alloc = 1'b1;
                  state_in   = S_RD;
               end
            end else begin
               ctrl.search = 1'b1;
               if (stat.hit) begin
                  state_in = S_RD;
               end else if (stat.last_slot) begin
                  if (stat.full) begin
                     state_in = S_RSP;
                  end else begin
                     ctrl.alloc = 1'b1;
                     state_in   = S_RD;
                  end
               end
            end
         end
         S_RD: begin
            ctrl.rd  = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_WR;
         end
         S_WR: begin
            ctrl.wr  = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            ctrl.respond = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

>>> rtl/ogu_datapath.sv
// Datapath: scaling, block split, key, block table search and cell update
module ogu_datapath import ogu_pkg::*; #(
   parameter int MAX_BLOCKS       = MAX_BLOCKS_DEF,
   parameter int BLOCK_COORD_BITS = BLOCK_COORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   output stat_type            stat,
   input  logic                csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]         csr_data,
   input  logic signed [31:0]  x_pos,
   input  logic signed [31:0]  y_pos,
   input  logic signed [15:0]  increment,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic signed [11:0]  rsp_block_row,
   output logic signed [11:0]  rsp_block_col,
   output logic [3:0]          rsp_cell_row,
   output logic [3:0]          rsp_cell_col,
   output logic [24:0]         rsp_block_key,
   output logic signed [15:0]  rsp_log_odds,
   output logic signed [11:0]  rsp_min_row,
   output logic signed [11:0]  rsp_max_row,
   output logic signed [11:0]  rsp_min_col,
   output logic signed [11:0]  rsp_max_col
);
   localparam int CB    = $clog2(CELLS_PER_BLOCK);
   localparam int BCB   = BLOCK_COORD_BITS;
   localparam int SB    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNTB  = $clog2(MAX_BLOCKS + 1);
   localparam int DEPTH = MAX_BLOCKS * CELLS_PER_BLOCK * CELLS_PER_BLOCK;
   localparam int AB    = $clog2(DEPTH);
   localparam int ZB    = BCB + 1;   // zigzag code width
   localparam int KW    = 2*ZB + 3;  // key accumulator width
   localparam logic signed [BCB-1:0] BMAX = {1'b0, {(BCB-1){1'b1}}};
   localparam logic signed [BCB-1:0] BMIN = {1'b1, {(BCB-1){1'b0}}};

   // configuration
   logic [31:0] grid_scale_ff;
   logic [14:0] limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_scale_ff <= GRID_SCALE_RESET;
         limit_ff      <= LOG_ODDS_LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_GRID_SCALE) begin
            grid_scale_ff <= csr_data;
         end else if (csr_index == CSR_LOG_ODDS_LIMIT) begin
            limit_ff <= csr_data[14:0];
         end
      end
   end

   // request capture and scaling multiply (32 by 33 signed each axis)
   logic signed [31:0] x_ff, y_ff;
   logic signed [15:0] inc_ff;
   logic signed [64:0] px_ff, py_ff;
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff   <= x_pos;
         y_ff   <= y_pos;
         inc_ff <= increment;
      end
      px_ff <= 65'(x_ff * $signed({1'b0, grid_scale_ff}));
      py_ff <= 65'(y_ff * $signed({1'b0, grid_scale_ff}));
   end

   // floor over 2^32 then split into block and cell (arithmetic shifts)
   logic signed [32:0] fx, fy;
   logic signed [32-CB:0] brw, bcw;
   assign fx  = px_ff[64:32];
   assign fy  = py_ff[64:32];
   assign brw = fx[32:CB];
   assign bcw = fy[32:CB];

   logic row_hi, row_lo, col_hi, col_lo;
   assign row_hi = brw > $signed({{(33-CB-BCB){1'b0}}, BMAX});
   assign row_lo = brw < $signed({{(33-CB-BCB){1'b1}}, BMIN});
   assign col_hi = bcw > $signed({{(33-CB-BCB){1'b0}}, BMAX});
   assign col_lo = bcw < $signed({{(33-CB-BCB){1'b1}}, BMIN});

   logic signed [BCB-1:0] br_ff, bc_ff;
   logic [CB-1:0] cr_ff, cc_ff;
   logic          range_ff;
   always_ff @(posedge clock) begin
      if (ctrl.split) begin
         br_ff    <= row_hi ? BMAX : (row_lo ? BMIN : brw[BCB-1:0]);
         bc_ff    <= col_hi ? BMAX : (col_lo ? BMIN : bcw[BCB-1:0]);
         cr_ff    <= fx[CB-1:0];
         cc_ff    <= fy[CB-1:0];
         range_ff <= row_hi | row_lo | col_hi | col_lo;
      end
   end
   assign stat.out_range = range_ff;

   // zigzag codes: value doubled, sign folded in
   logic [ZB-1:0] zr, zc;
   assign zr = br_ff[BCB-1] ? ~{br_ff, 1'b0} : {br_ff, 1'b0};
   assign zc = bc_ff[BCB-1] ? ~{bc_ff, 1'b0} : {bc_ff, 1'b0};

   // key: squaring registered, then halve
   logic [ZB:0]       zsum;
   logic [KW-1:0]     key_ff;
   assign zsum = {1'b0, zr} + {1'b0, zc};
   always_ff @(posedge clock) begin
      if (ctrl.key) begin
         key_ff <= KW'(zsum) * KW'(zsum) + KW'(zr) + KW'({zc, 1'b0}) + KW'(zc);
      end
   end

   // bounding box
   logic signed [BCB-1:0] rmin_ff, rmax_ff, cmin_ff, cmax_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rmin_ff <= BMAX;
         cmin_ff <= BMAX;
         rmax_ff <= BMIN;
         cmax_ff <= BMIN;
      end else if (ctrl.key) begin
         if (br_ff < rmin_ff) rmin_ff <= br_ff;
         if (br_ff > rmax_ff) rmax_ff <= br_ff;
         if (bc_ff < cmin_ff) cmin_ff <= bc_ff;
         if (bc_ff > cmax_ff) cmax_ff <= bc_ff;
      end
   end

   // block table: slots filled in order, searched one slot a cycle;
   // the table is addressed with the next slot so its read data matches slot_ff
   logic [2*BCB-1:0] tbl_rd;
   logic [CNTB-1:0]  count_ff;
   logic [SB-1:0]    slot_ff, slot_in;
   logic [CNTB-1:0]  slot_ext;
   logic             hit;
   assign slot_ext = CNTB'(slot_ff);
   assign hit      = tbl_rd == {br_ff, bc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.alloc) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.key) begin
         slot_in = '0;
      end else if (ctrl.alloc) begin
         slot_in = count_ff[SB-1:0];
      end else if (ctrl.search && !hit) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   ogu_ram #(.WIDTH(2*BCB), .DEPTH(2**SB)) u_table (
      .clock   (clock),
      .wr_en   (ctrl.alloc),
      .addr    (slot_in),
      .wr_data ({br_ff, bc_ff}),
      .rd_data (tbl_rd)
   );

   assign stat.hit       = hit;
   assign stat.empty     = count_ff == '0;
   assign stat.last_slot = slot_ext + 1'b1 == count_ff;
   assign stat.full      = count_ff == CNTB'(MAX_BLOCKS);

   logic found_ff, new_ff;
   always_ff @(posedge clock) begin
      if (ctrl.key) begin
         found_ff <= 1'b0;
         new_ff   <= 1'b0;
      end else if (ctrl.alloc) begin
         found_ff <= 1'b1;
         new_ff   <= 1'b1;
      end else if (ctrl.search && hit) begin
         found_ff <= 1'b1;
      end
   end

   // cell memory with clearing sweep after reset
   logic [AB-1:0]  clr_ff;
   logic           clr_last;
   logic [AB-1:0]  addr;
   logic [15:0]    rd_data;
   logic [15:0]    wr_data;
   logic           wr_en;
   assign clr_last = clr_ff == AB'(DEPTH - 1);
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctrl.clear && !clr_last) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end
   assign stat.clear_done = ctrl.clear && clr_last;

   assign addr  = ctrl.clear ? clr_ff : AB'({slot_ff, cr_ff, cc_ff});
   assign wr_en = ctrl.clear | ctrl.wr;

   // saturating add
   logic signed [16:0] sum;
   logic signed [16:0] lim;
   logic signed [15:0] sat;
   assign sum = 17'($signed(rd_data)) + 17'(inc_ff);
   assign lim = $signed({2'b00, limit_ff});
   assign sat = (sum > lim) ? lim[15:0] : ((sum < -lim) ? 16'(-lim) : sum[15:0]);
   assign wr_data = ctrl.clear ? 16'd0 : sat;

   ogu_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   logic signed [15:0] lo_ff;
   always_ff @(posedge clock) begin
      if (ctrl.key) begin
         lo_ff <= '0;
      end else if (ctrl.wr) begin
         lo_ff <= sat;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= ctrl.respond;
      end
      if (ctrl.respond) begin
         rsp_status    <= range_ff ? STATUS_RANGE :
                          (!found_ff ? STATUS_FULL : (new_ff ? STATUS_NEW : STATUS_UPDATED));
         rsp_block_row <= 12'(br_ff);
         rsp_block_col <= 12'(bc_ff);
         rsp_cell_row  <= 4'(cr_ff);
         rsp_cell_col  <= 4'(cc_ff);
         rsp_block_key <= range_ff ? 25'd0 : key_ff[25:1];
         rsp_log_odds  <= range_ff ? 16'sd0 : lo_ff;
         rsp_min_row   <= 12'(rmin_ff);
         rsp_max_row   <= 12'(rmax_ff);
         rsp_min_col   <= 12'(cmin_ff);
         rsp_max_col   <= 12'(cmax_ff);
      end
   end
endmodule

>>> bench/tb.sv
// Self-checking testbench for the occupancy grid log-odds update block
module tb import ogu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CPB        = CELLS_PER_BLOCK;
   localparam int NBLK       = MAX_BLOCKS_DEF;
   localparam int HALF       = 1 << (BLOCK_COORD_BITS_DEF - 1);
   localparam int NCELL      = NBLK * CPB * CPB;
   localparam int CYCLE_CAP  = 600000;

   typedef struct {
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic signed [15:0] increment;
   } meas_type;

   typedef struct {
      logic [1:0]         status;
      logic signed [11:0] block_row, block_col;
      logic [3:0]         cell_row, cell_col;
      logic [24:0]        block_key;
      logic signed [15:0] log_odds;
      logic signed [11:0] min_row, max_row, min_col, max_col;
   } update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_x_pos = '0;
   logic signed [31:0] req_y_pos = '0;
   logic signed [15:0] req_increment = '0;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic signed [11:0] rsp_block_row, rsp_block_col;
   logic [3:0] rsp_cell_row, rsp_cell_col;
   logic [24:0] rsp_block_key;
   logic signed [15:0] rsp_log_odds;
   logic signed [11:0] rsp_min_row, rsp_max_row, rsp_min_col, rsp_max_col;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Mirror of the block's state and registers
   longint unsigned    scale_q = GRID_SCALE_RESET;
   longint             limit_q = LOG_ODDS_LIMIT_RESET;
   int                 slot_row [NBLK];
   int                 slot_col [NBLK];
   bit                 slot_used [NBLK];
   int                 slots_taken = 0;
   logic signed [15:0] cell_mem [NCELL];
   longint             box_rmin = HALF - 1, box_rmax = -HALF;
   longint             box_cmin = HALF - 1, box_cmax = -HALF;

   meas_type   meas_q[$];
   update_type update_q[$];
   int      idle_pct = 36;
   int      errors = 0;
   int      cycles = 0;

   occupancy_grid_log_odds_update dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint zigzag(longint i);
      return (i < 0) ? (-2 * i - 1) : (2 * i);
   endfunction

   // Predict one update and advance the mirrored state
   function automatic update_type predict_update(meas_type m);
      update_type u;
      longint fx, fy, br, bc, cr, cc, fr, fc, sum, key, lo;
      int slot, idx;
      bit hit;
      fx = (longint'(m.x_pos) * longint'(scale_q)) >>> 32;
      fy = (longint'(m.y_pos) * longint'(scale_q)) >>> 32;
      br = fx >>> 4;
      bc = fy >>> 4;
      cr = fx & 15;
      cc = fy & 15;
      key = 0;
      lo = 0;
      hit = 0;
      slot = 0;
      if (br < -HALF || br >= HALF || bc < -HALF || bc >= HALF) begin
         u.status = STATUS_RANGE;
         br = (br < -HALF) ? -HALF : ((br >= HALF) ? HALF - 1 : br);
         bc = (bc < -HALF) ? -HALF : ((bc >= HALF) ? HALF - 1 : bc);
      end else begin
         fr = zigzag(br);
         fc = zigzag(bc);
         sum = fr + fc;
         key = (sum * sum + fr + 3 * fc) / 2;
         if (br > box_rmax) box_rmax = br;
         if (br < box_rmin) box_rmin = br;
         if (bc > box_cmax) box_cmax = bc;
         if (bc < box_cmin) box_cmin = bc;
         for (int s = 0; s < NBLK; s++) begin
            if (!hit && slot_used[s] && slot_row[s] == br && slot_col[s] == bc) begin
               hit = 1;
               slot = s;
            end
         end
         if (hit) begin
            u.status = STATUS_UPDATED;
         end else if (slots_taken < NBLK) begin
            slot = slots_taken;
            slots_taken++;
            slot_used[slot] = 1;
            slot_row[slot] = br;
            slot_col[slot] = bc;
            u.status = STATUS_NEW;
            hit = 1;
         end else begin
            u.status = STATUS_FULL;
         end
         if (hit) begin
            idx = (slot * CPB + cr) * CPB + cc;
            lo = longint'(cell_mem[idx]) + longint'(m.increment);
            if (lo > limit_q) lo = limit_q;
            if (lo < -limit_q) lo = -limit_q;
            cell_mem[idx] = lo[15:0];
         end
      end
      u.block_row = br[11:0];
      u.block_col = bc[11:0];
      u.cell_row  = cr[3:0];
      u.cell_col  = cc[3:0];
      u.block_key = key[24:0];
      u.log_odds  = lo[15:0];
      u.min_row   = box_rmin[11:0];
      u.max_row   = box_rmax[11:0];
      u.min_col   = box_cmin[11:0];
      u.max_col   = box_cmax[11:0];
      return u;
   endfunction

   // Random request: mostly blocks from a pool a little larger than the table
   function automatic meas_type rand_meas();
      meas_type m;
      int pick, k;
      logic [11:0] r, c;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         k = $urandom_range(0, 79);
         r = 12'(k % 10 - 5);
         c = 12'(k / 10 - 4);
         m.x_pos = {{4{r[11]}}, r, 16'($urandom)};
         m.y_pos = {{4{c[11]}}, c, 16'($urandom)};
      end else if (pick < 85) begin
         m.x_pos = $urandom;
         m.y_pos = $urandom;
      end else begin
         m.x_pos = 32'(int'($urandom_range(0, 80000)) - 40000);
         m.y_pos = 32'(int'($urandom_range(0, 80000)) - 40000);
      end
      m.increment = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'(int'($urandom_range(0, 2000)) - 1000);
      return m;
   endfunction

   function automatic meas_type mk(logic [31:0] x, logic [31:0] y, logic [15:0] inc);
      meas_type m;
      m.x_pos = x;
      m.y_pos = y;
      m.increment = inc;
      return m;
   endfunction

   // Request driver
   always @(posedge clock) begin : drive_req
      meas_type m;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start)
            update_q.push_back(predict_update(mk(req_x_pos, req_y_pos, req_increment)));
         if (meas_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            m = meas_q.pop_front();
            start <= 1'b1;
            req_x_pos <= m.x_pos;
            req_y_pos <= m.y_pos;
            req_increment <= m.increment;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, nm, e, a);
         errors++;
      end
   endtask

   // Result monitor
   always @(posedge clock) begin : watch_rsp
      update_type u;
      if (!reset && rsp_strobe) begin
         if (update_q.size() == 0) begin
            $display("%0t: unexpected result, status %h", $time, rsp_status);
            errors++;
         end else begin
            u = update_q.pop_front();
            check_field("status", u.status, rsp_status);
            check_field("block_row", u.block_row, rsp_block_row);
            check_field("block_col", u.block_col, rsp_block_col);
            check_field("cell_row", u.cell_row, rsp_cell_row);
            check_field("cell_col", u.cell_col, rsp_cell_col);
            check_field("block_key", u.block_key, rsp_block_key);
            check_field("log_odds", u.log_odds, rsp_log_odds);
            check_field("min_row", u.min_row, rsp_min_row);
            check_field("max_row", u.max_row, rsp_max_row);
            check_field("min_col", u.min_col, rsp_min_col);
            check_field("max_col", u.max_col, rsp_max_col);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_GRID_SCALE) scale_q = val;
      else limit_q = val & 32'h7FFF;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (meas_q.size() > 0 || start || update_q.size() > 0) @(posedge clock);
   endtask

   task automatic run_phase(logic [31:0] scale, logic [31:0] lim, int n, int idle);
      drain();
      csr_write(CSR_GRID_SCALE, scale);
      csr_write(CSR_LOG_ODDS_LIMIT, lim);
      idle_pct = idle;
      for (int i = 0; i < n; i++) meas_q.push_back(rand_meas());
   endtask

   initial begin
      foreach (cell_mem[i]) cell_mem[i] = '0;
      foreach (slot_used[i]) slot_used[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: saturation both ways, negative cells, range edges
      meas_q.push_back(mk(32'h0, 32'h0, 16'h7FFF));
      meas_q.push_back(mk(32'h0, 32'h0, 16'h7FFF));
      meas_q.push_back(mk(32'h0, 32'h0, 16'h8000));
      meas_q.push_back(mk(32'h0, 32'h0, 16'h8000));
      meas_q.push_back(mk(32'h0, 32'h0, 16'h0000));
      meas_q.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0100));
      meas_q.push_back(mk(32'h07FF_FFFF, 32'hF800_0000, 16'hFF00));
      meas_q.push_back(mk(32'hF800_0000, 32'h07FF_FFFF, 16'h0001));
      meas_q.push_back(mk(32'h0800_0000, 32'h0, 16'h0010));
      meas_q.push_back(mk(32'h0, 32'hF7FF_FFFF, 16'h0010));
      meas_q.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF));
      meas_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000));
      meas_q.push_back(mk(32'h0001_8000, 32'hFFFE_4000, 16'h1234));
      meas_q.push_back(mk(32'h0001_8000, 32'hFFFE_4000, 16'hEDCC));
      meas_q.push_back(mk(32'h0000_F000, 32'h0000_0FFF, 16'h0042));

      run_phase(32'd1048576, 32'd200, 300, 36);
      run_phase(32'hFFFF_FFFF, 32'd32767, 150, 36);
      run_phase(32'd1, 32'd1, 100, 62);
      run_phase(32'd1048576, 32'hFFFF_8000, 100, 62);
      run_phase(32'd196608, 32'd5000, 150, 0);
      run_phase(32'd1048576, 32'd32767, 150, 0);

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> occupancy_grid_log_odds_update.f
rtl/ogu_pkg.sv
rtl/ogu_ram.sv
rtl/ogu_ctrl.sv
rtl/ogu_datapath.sv
rtl/occupancy_grid_log_odds_update.sv
bench/tb.sv
